[design/tcs_pkg.sv]
// Shared widths and constants for the temporal color smoother.
// Used by tcs_div, temporal_color_smoother_unit and the testbench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tcs_pkg;

    localparam int ChanW    = 8;   // bits of one color channel
    localparam int NumChan  = 4;   // alpha, red, green, blue
    localparam int ChanIdxW = 2;
    localparam int ColorW   = ChanW * NumChan;
    localparam int MixSumW  = 12;  // 2*o + 3*n + 5*c, at most 2550
    localparam int RecipW   = 17;
    localparam int MixProdW = MixSumW + RecipW;
    localparam int SqW      = 16;  // d*d, at most 65025
    localparam int SumW     = 18;  // sum over four channels, at most 260100
    localparam int ProdW    = 24;  // limit * d*d
    localparam int QuotW    = 8;   // scaled step never exceeds the limit
    localparam int QuotIdxW = 3;
    localparam int StepW    = 10;  // signed newer +/- step

    // floor(x / 10) == (x * 52429) >> 19 for every x below 43690
    localparam logic [RecipW-1:0] DivTenRecip = 17'd52429;
    localparam int                DivTenShift = 19;

    localparam logic [ChanW-1:0] LimitReset = 8'd5;

endpackage

`default_nettype wire

[design/tcs_div.sv]
// Restoring divider, one quotient bit per cycle, for the scaled step.
// Quotient is known to fit in tcs_pkg::QuotW bits. Depends on tcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcs_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [tcs_pkg::ProdW-1:0]  dividend,
    input  wire logic [tcs_pkg::SumW-1:0]   divisor,
    output logic                            done,
    output logic [tcs_pkg::QuotW-1:0]       quotient
);

    localparam int TrialW = tcs_pkg::SumW + tcs_pkg::QuotW;

    logic [tcs_pkg::ProdW-1:0]    rem_reg, rem_next;
    logic [tcs_pkg::SumW-1:0]     dsr_reg;
    logic [tcs_pkg::QuotW-1:0]    q_reg, q_next;
    logic [tcs_pkg::QuotIdxW-1:0] cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;

    logic [TrialW-1:0] shifted;
    logic [TrialW-1:0] rem_ext;
    logic              fits;

    assign shifted = {{tcs_pkg::QuotW{1'b0}}, dsr_reg} << cnt_reg;
    assign rem_ext = {{(TrialW - tcs_pkg::ProdW){1'b0}}, rem_reg};
    assign fits    = rem_ext >= shifted;

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend;
            q_next    = '0;
            cnt_next  = tcs_pkg::QuotIdxW'(tcs_pkg::QuotW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next         = rem_reg - shifted[tcs_pkg::ProdW-1:0];
                q_next[cnt_reg]  = 1'b1;
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (start)
        begin
            dsr_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider did not go busy after start");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !$past(start)) |=> !done_reg)
        else $error("divider done held longer than one cycle");
`endif

endmodule

`default_nettype wire

[design/temporal_color_smoother_unit.sv]
// Temporal color smoother: one averaged ARGB color in, one smoothed color out.
// Sequencer over channels with a shared mix/square step and tcs_div.
// Depends on tcs_pkg and tcs_div.
//
// Channels: input item on in_valid/in_ready, result item on out_valid/out_ready,
// change_limit written through cfg_valid/cfg_ready/cfg_data (always ready;
// write it only while the block is idle).
// Path from input accept to result valid:
//   first frame after reset: input passes straight to the finish step,
//   step not limited: a mix and a square step per channel, then the check,
//   step limited: adds per channel one multiply, eight divider steps and one
//   to apply the step.
// One item is in work at a time; in_ready is high only between items.
// A finished result sits in the output register, and the next item is taken
// meanwhile; it is only held back at its end while that result is not taken.
// Reset clears the history (next item is a first frame), sets change_limit
// to 5 and drops any result not yet taken.
`timescale 1ns / 1ps
`default_nettype none

module temporal_color_smoother_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [tcs_pkg::ChanW-1:0]  cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [tcs_pkg::ChanW-1:0]  in_alpha,
    input  wire logic [tcs_pkg::ChanW-1:0]  in_red,
    input  wire logic [tcs_pkg::ChanW-1:0]  in_green,
    input  wire logic [tcs_pkg::ChanW-1:0]  in_blue,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [tcs_pkg::ChanW-1:0]       out_alpha,
    output logic [tcs_pkg::ChanW-1:0]       out_red,
    output logic [tcs_pkg::ChanW-1:0]       out_green,
    output logic [tcs_pkg::ChanW-1:0]       out_blue,
    output logic                            step_limited,
    output logic                            first_frame
);

    localparam int W  = tcs_pkg::ChanW;
    localparam int NC = tcs_pkg::NumChan;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MIX  = 3'd1;
    localparam logic [2:0] ST_SQ   = 3'd2;
    localparam logic [2:0] ST_CHK  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    localparam logic [tcs_pkg::ChanIdxW-1:0] LastChan = tcs_pkg::ChanIdxW'(NC - 1);

    function automatic logic [W-1:0] chan_of(input logic [tcs_pkg::ColorW-1:0] packed_c,
                                             input logic [tcs_pkg::ChanIdxW-1:0] idx);
        logic [W-1:0] v;
        v = '0;
        unique case (idx)
            2'd0:    v = packed_c[31:24];
            2'd1:    v = packed_c[23:16];
            2'd2:    v = packed_c[15:8];
            default: v = packed_c[7:0];
        endcase
        return v;
    endfunction

    // control
    logic [2:0]                    state_reg, state_next;
    logic [tcs_pkg::ChanIdxW-1:0]  ch_reg, ch_next;
    logic                          hist_valid_reg, hist_valid_next;
    logic                          limited_reg, limited_next;
    logic                          first_reg, first_next;
    logic                          out_valid_reg, out_valid_next;
    logic [W-1:0]                  limit_reg, limit_next;
    logic [tcs_pkg::SumW-1:0]      sum_reg, sum_next;
    logic [tcs_pkg::ColorW-1:0]    older_reg, older_next;
    logic [tcs_pkg::ColorW-1:0]    newer_reg, newer_next;

    // per-channel payload
    logic [W-1:0]           cur_reg [NC];
    logic [W-1:0]           mix_reg [NC];
    logic                   neg_reg [NC];
    logic [tcs_pkg::SqW-1:0] sq_reg [NC];
    logic [W-1:0]           res_reg [NC];
    logic [W-1:0]           out_alpha_reg, out_red_reg, out_green_reg, out_blue_reg;
    logic                   out_limited_reg, out_first_reg;

    logic in_fire;
    logic out_free;
    logic [tcs_pkg::ColorW-1:0] res_packed;

    // shared mix / square datapath on the selected channel
    logic [W-1:0]                  older_ch, newer_ch, cur_ch;
    logic [tcs_pkg::MixSumW-1:0]   mix_sum;
    logic [tcs_pkg::MixProdW-1:0]  mix_prod;
    logic [W-1:0]                  mix_val;
    logic signed [W+1:0]           diff;
    logic [W-1:0]                  mag;
    logic [tcs_pkg::SqW-1:0]       sq_val;

    // scaled step
    logic                          div_start;
    logic                          div_done;
    logic [tcs_pkg::ProdW-1:0]     div_dividend;
    logic [tcs_pkg::QuotW-1:0]     div_q;
    logic signed [tcs_pkg::StepW-1:0] step_sum;
    logic [W-1:0]                  step_val;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;

    assign older_ch = chan_of(older_reg, ch_reg);
    assign newer_ch = chan_of(newer_reg, ch_reg);
    assign cur_ch   = cur_reg[ch_reg];

    assign mix_sum  = {3'b0, older_ch, 1'b0}
                    + {4'b0, newer_ch} + {3'b0, newer_ch, 1'b0}
                    + {4'b0, cur_ch} + {2'b0, cur_ch, 2'b0};
    assign mix_prod = {{tcs_pkg::RecipW{1'b0}}, mix_sum}
                    * {{tcs_pkg::MixSumW{1'b0}}, tcs_pkg::DivTenRecip};
    assign mix_val  = mix_prod[tcs_pkg::DivTenShift +: W];

    assign diff   = $signed({2'b0, mix_reg[ch_reg]}) - $signed({2'b0, newer_ch});
    assign mag    = diff[W+1] ? W'(-diff) : diff[W-1:0];
    assign sq_val = {8'b0, mag} * {8'b0, mag};

    assign div_dividend = {16'b0, limit_reg} * {8'b0, sq_reg[ch_reg]};

    assign step_sum = neg_reg[ch_reg]
                    ? $signed({2'b0, newer_ch}) - $signed({2'b0, div_q})
                    : $signed({2'b0, newer_ch}) + $signed({2'b0, div_q});
    // clamp to 0..255
    assign step_val = step_sum[tcs_pkg::StepW-1] ? '0
                    : (step_sum[W] ? '1 : step_sum[W-1:0]);

    assign res_packed = {res_reg[0], res_reg[1], res_reg[2], res_reg[3]};

    tcs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (sum_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next      = state_reg;
        ch_next         = ch_reg;
        hist_valid_next = hist_valid_reg;
        limited_next    = limited_reg;
        first_next      = first_reg;
        out_valid_next  = out_valid_reg;
        limit_next      = limit_reg;
        sum_next        = sum_reg;
        older_next      = older_reg;
        newer_next      = newer_reg;
        div_start       = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            limit_next = cfg_data;
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    ch_next      = '0;
                    sum_next     = '0;
                    limited_next = 1'b0;
                    first_next   = !hist_valid_reg;
                    state_next   = hist_valid_reg ? ST_MIX : ST_FIN;
                end
            end
            ST_MIX:
            begin
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                sum_next = sum_reg + {2'b0, sq_val};
                if (ch_reg == LastChan)
                begin
                    state_next = ST_CHK;
                end
                else
                begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = ST_MIX;
                end
            end
            ST_CHK:
            begin
                ch_next = '0;
                if (sum_reg > {{(tcs_pkg::SumW - W){1'b0}}, limit_reg})
                begin
                    limited_next = 1'b1;
                    state_next   = ST_MUL;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_MUL:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (ch_reg == LastChan)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_FIN:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    hist_valid_next = 1'b1;
                    older_next      = first_reg ? res_packed : newer_reg;
                    newer_next      = res_packed;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ch_reg         <= '0;
            hist_valid_reg <= 1'b0;
            limited_reg    <= 1'b0;
            first_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            limit_reg      <= tcs_pkg::LimitReset;
            sum_reg        <= '0;
            older_reg      <= '0;
            newer_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            ch_reg         <= ch_next;
            hist_valid_reg <= hist_valid_next;
            limited_reg    <= limited_next;
            first_reg      <= first_next;
            out_valid_reg  <= out_valid_next;
            limit_reg      <= limit_next;
            sum_reg        <= sum_next;
            older_reg      <= older_next;
            newer_reg      <= newer_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cur_reg[0] <= in_alpha;
            cur_reg[1] <= in_red;
            cur_reg[2] <= in_green;
            cur_reg[3] <= in_blue;
            // pass-through result for a first frame
            res_reg[0] <= in_alpha;
            res_reg[1] <= in_red;
            res_reg[2] <= in_green;
            res_reg[3] <= in_blue;
        end
        if (state_reg == ST_MIX)
        begin
            mix_reg[ch_reg] <= mix_val;
        end
        if (state_reg == ST_SQ)
        begin
            neg_reg[ch_reg] <= diff[W+1];
            sq_reg[ch_reg]  <= sq_val;
        end
        if ((state_reg == ST_CHK) && !(sum_reg > {{(tcs_pkg::SumW - W){1'b0}}, limit_reg}))
        begin
            for (int i = 0; i < NC; i++)
            begin
                res_reg[i] <= mix_reg[i];
            end
        end
        if ((state_reg == ST_DIV) && div_done)
        begin
            res_reg[ch_reg] <= step_val;
        end
        if ((state_reg == ST_FIN) && out_free)
        begin
            out_alpha_reg   <= res_reg[0];
            out_red_reg     <= res_reg[1];
            out_green_reg   <= res_reg[2];
            out_blue_reg    <= res_reg[3];
            out_limited_reg <= limited_reg;
            out_first_reg   <= first_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_alpha    = out_alpha_reg;
    assign out_red      = out_red_reg;
    assign out_green    = out_green_reg;
    assign out_blue     = out_blue_reg;
    assign step_limited = out_limited_reg;
    assign first_frame  = out_first_reg;

`ifndef SYNTHESIS
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_limited_reg && out_first_reg))
        else $error("result marked both first frame and step limited");
    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide step");
    a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FIN) && out_free) |=> (hist_valid_reg && out_valid_reg))
        else $error("finished item did not reach the output register");
    a_first_direct: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !hist_valid_reg) |=> (state_reg == ST_FIN))
        else $error("first frame did not pass straight through");
`endif

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Testbench for temporal_color_smoother_unit: directed and random color items,
// with a scoreboard class that predicts each smoothed color and checks it.
// Depends on tcs_pkg and the temporal_color_smoother_unit RTL.
`timescale 1ns / 1ps

module tb;

    typedef logic [tcs_pkg::ChanW-1:0] chan_t;

    typedef struct packed {
        chan_t alpha;
        chan_t red;
        chan_t green;
        chan_t blue;
        logic  limited;
        logic  first;
    } smoothed_t;

    localparam int StallLimit = 3000;  // cycles with no item accepted anywhere
    localparam int PressureAt = 120;   // results taken before the long hold-off
    localparam int HoldCycles = 400;
    localparam int IdlePct    = 18;
    localparam int PhaseItems = 50;

    class color_scoreboard;
        int        limit;
        bit        primed;
        int        older[4];
        int        newer[4];
        smoothed_t smoothed_q[$];
        int        errors;

        function new();
            limit  = tcs_pkg::LimitReset;
            primed = 1'b0;
            errors = 0;
            foreach (older[i])
            begin
                older[i] = 0;
                newer[i] = 0;
            end
        endfunction

        function void set_limit(int value);
            limit = value;
        endfunction

        function int pending();
            return smoothed_q.size();
        endfunction

        // Predict the smoothed color for an accepted input item.
        function void note_color(chan_t a, chan_t r, chan_t g, chan_t b);
            int        cur[4];
            int        mix[4];
            int        diff[4];
            int        res[4];
            int        sq_sum;
            int        mag;
            int        step;
            int        i;
            smoothed_t exp_color;

            cur = '{a, r, g, b};
            sq_sum = 0;
            exp_color.limited = 1'b0;
            exp_color.first   = 1'b0;
            if (!primed)
            begin
                primed = 1'b1;
                exp_color.first = 1'b1;
                for (i = 0; i < 4; i++)
                begin
                    res[i]   = cur[i];
                    older[i] = cur[i];
                    newer[i] = cur[i];
                end
            end
            else
            begin
                for (i = 0; i < 4; i++)
                begin
                    mix[i]  = (2 * older[i] + 3 * newer[i] + 5 * cur[i]) / 10;
                    diff[i] = mix[i] - newer[i];
                    sq_sum += diff[i] * diff[i];
                    res[i]  = mix[i];
                end
                if (sq_sum > limit)
                begin
                    exp_color.limited = 1'b1;
                    for (i = 0; i < 4; i++)
                    begin
                        mag  = (diff[i] < 0) ? -diff[i] : diff[i];
                        step = (limit * mag * mag) / sq_sum;
                        if (diff[i] < 0)
                            step = -step;
                        res[i] = newer[i] + step;
                        if (res[i] < 0)
                            res[i] = 0;
                        if (res[i] > 255)
                            res[i] = 255;
                    end
                end
                for (i = 0; i < 4; i++)
                begin
                    older[i] = newer[i];
                    newer[i] = res[i];
                end
            end
            exp_color.alpha = chan_t'(res[0]);
            exp_color.red   = chan_t'(res[1]);
            exp_color.green = chan_t'(res[2]);
            exp_color.blue  = chan_t'(res[3]);
            smoothed_q.push_back(exp_color);
        endfunction

        function void match_field(string name, int want, int got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(smoothed_t got);
            smoothed_t want;

            if (smoothed_q.size() == 0)
            begin
                $error("result item with no expected color pending");
                errors++;
                return;
            end
            want = smoothed_q.pop_front();
            match_field("out_alpha", want.alpha, got.alpha);
            match_field("out_red", want.red, got.red);
            match_field("out_green", want.green, got.green);
            match_field("out_blue", want.blue, got.blue);
            match_field("step_limited", want.limited, got.limited);
            match_field("first_frame", want.first, got.first);
        endfunction
    endclass

    logic  clk;
    logic  rst_n;
    logic  cfg_valid;
    logic  cfg_ready;
    chan_t cfg_data;
    logic  in_valid;
    logic  in_ready;
    chan_t in_alpha;
    chan_t in_red;
    chan_t in_green;
    chan_t in_blue;
    logic  out_valid;
    logic  out_ready;
    chan_t out_alpha;
    chan_t out_red;
    chan_t out_green;
    chan_t out_blue;
    logic  step_limited;
    logic  first_frame;

    color_scoreboard sb = new();
    bit              no_idle;
    int              stall_cycles;
    int              last_color[4];

    temporal_color_smoother_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_alpha     (in_alpha),
        .in_red       (in_red),
        .in_green     (in_green),
        .in_blue      (in_blue),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_alpha    (out_alpha),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .step_limited (step_limited),
        .first_frame  (first_frame)
    );

    initial
        clk = 1'b0;

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_color(in_alpha, in_red, in_green, in_blue);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result({out_alpha, out_red, out_green, out_blue,
                             step_limited, first_frame});
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles == StallLimit)
        begin
            $display("FAIL temporal_color_smoother_unit");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Result side: random stalls, plus one long hold-off so the block backs up.
    initial
    begin : result_side
        int taken;
        int hold_left;
        bit pressed;

        taken     = 0;
        hold_left = 0;
        pressed   = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                taken++;
            if (!pressed && taken == PressureAt)
            begin
                pressed   = 1'b1;
                hold_left = HoldCycles;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= no_idle || ($urandom_range(99) >= IdlePct);
        end
    end

    function bit idle_roll();
        return !no_idle && ($urandom_range(99) < IdlePct);
    endfunction

    // Offer one color item and hold it until accepted; returns at the accepting edge.
    task send_color(input int a, input int r, input int g, input int b);
        while (idle_roll())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_alpha <= chan_t'(a);
        in_red   <= chan_t'(r);
        in_green <= chan_t'(g);
        in_blue  <= chan_t'(b);
        last_color = '{a, r, g, b};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task write_limit(input int value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= chan_t'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_limit(value);
    endtask

    // Mostly slow drifts and repeats near the last color, so the step limit
    // is hit and missed often; the rest are jumps and full-scale values.
    task send_random(input int count);
        int n;
        int i;
        int pick;
        int chan[4];

        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            for (i = 0; i < 4; i++)
            begin
                if (pick < 55)
                begin
                    chan[i] = last_color[i] + $urandom_range(6) - 3;
                    if (chan[i] < 0)
                        chan[i] = 0;
                    if (chan[i] > 255)
                        chan[i] = 255;
                end
                else if (pick < 65)
                    chan[i] = last_color[i];
                else if (pick < 72)
                    chan[i] = $urandom_range(1) ? 255 : 0;
                else
                    chan[i] = $urandom_range(255);
            end
            send_color(chan[0], chan[1], chan[2], chan[3]);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        in_alpha     = '0;
        in_red       = '0;
        in_green     = '0;
        in_blue      = '0;
        no_idle      = 1'b0;
        stall_cycles = 0;
        last_color   = '{0, 0, 0, 0};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First frame passes through, then a repeat gives no change at all.
        send_color(0, 0, 0, 0);
        send_color(0, 0, 0, 0);
        // Small alpha rise stays under the reset limit and leaves newer alpha at 2.
        send_color(4, 0, 0, 0);
        // Drop back to black with a tighter limit: the step overshoots below zero.
        write_limit(3);
        send_color(0, 0, 0, 0);

        write_limit(255);
        send_color(255, 255, 255, 255);
        send_color(255, 0, 255, 0);
        send_color(0, 255, 0, 255);
        send_color(255, 255, 255, 255);
        send_color(255, 255, 255, 255);
        send_color(0, 0, 0, 0);
        send_color(8'hAA, 8'h55, 8'hAA, 8'h55);
        send_color(8'h55, 8'hAA, 8'h55, 8'hAA);

        // Zero limit: any change repeats the newer color.
        write_limit(0);
        send_color(255, 0, 128, 1);
        send_color(255, 0, 128, 1);
        send_color(17, 200, 64, 99);

        write_limit(1);
        send_color(1, 2, 254, 253);
        send_color(1, 2, 254, 253);
        send_color(128, 127, 0, 255);

        write_limit(1);
        send_random(PhaseItems);
        write_limit(255);
        send_random(PhaseItems);
        write_limit($urandom_range(16, 2));
        no_idle = 1'b1;
        send_random(PhaseItems);
        no_idle = 1'b0;
        write_limit($urandom_range(255, 1));
        send_random(PhaseItems);
        write_limit(5);
        send_random(PhaseItems);
        write_limit($urandom_range(254, 17));
        send_random(PhaseItems);
        write_limit(1);
        send_random(PhaseItems);
        write_limit(255);
        send_random(PhaseItems);

        wait_drained();
        repeat (60) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS temporal_color_smoother_unit");
        else
            $display("FAIL temporal_color_smoother_unit");
        $finish;
    end

endmodule

[sim.f]
design/tcs_pkg.sv
design/tcs_div.sv
design/temporal_color_smoother_unit.sv
tb/sv/tb.sv
